// ----- hw/rtl/ltie_pkg.sv -----
package ltie_pkg;

    localparam int LineLimitDefault = 128;
    localparam int LenWidth         = 8;

    localparam logic [7:0] CH_NUL   = 8'd0;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_VT    = 8'd11;
    localparam logic [7:0] CH_FF    = 8'd12;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;

    localparam logic [7:0] IDX_FIRST  = 8'd3;
    localparam logic [7:0] IDX_SECOND = 8'd4;
    localparam logic [7:0] IDX_MAX    = 8'd255;

    typedef enum logic [1:0] {
        PH_AWAIT  = 2'd0,
        PH_DIGITS = 2'd1,
        PH_DONE   = 2'd2
    } phase_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] first_value;
        logic [31:0] second_value;
        logic [7:0]  token_count;
    } result_t;

endpackage

// ----- hw/rtl/line_token_integer_extractor_unit.sv -----
// Parses a byte stream line by line: tokens split on space and carriage return,
// the third and fourth tokens are converted to signed 32-bit integers with atoi
// rules, and each line feed yields one item with both values and the token count.
// One byte is taken every cycle unless a line's result is still waiting at the output.
// A byte passes an input register and combinational parsing logic into an output
// register; a line feed leaves the input register only when the output register has room.
// Only the first LINE_LIMIT bytes of a line, and none after a NUL byte, are parsed.
module line_token_integer_extractor_unit
    import ltie_pkg::*;
#(
    parameter int LINE_LIMIT = LineLimitDefault
)
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_byte_in,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_first_value,
    output logic signed [31:0] m_second_value,
    output logic [7:0]         m_token_count
);

    logic       byte_valid;
    logic [7:0] byte_data;
    logic       byte_take;
    logic       res_space;
    result_t    res;

    ltie_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_byte_in  (s_byte_in),
        .byte_valid (byte_valid),
        .byte_data  (byte_data),
        .byte_take  (byte_take)
    );

    ltie_parser #(
        .LINE_LIMIT (LINE_LIMIT)
    ) u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_valid (byte_valid),
        .byte_data  (byte_data),
        .byte_take  (byte_take),
        .res_space  (res_space),
        .res        (res)
    );

    ltie_out_reg u_out_reg (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .res            (res),
        .res_space      (res_space),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_first_value  (m_first_value),
        .m_second_value (m_second_value),
        .m_token_count  (m_token_count)
    );

endmodule

// ----- hw/rtl/ltie_in_reg.sv -----
module ltie_in_reg
    import ltie_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_byte_in,
    output logic       byte_valid,
    output logic [7:0] byte_data,
    input  logic       byte_take
);

    logic       valid_reg;
    logic [7:0] byte_reg;

    assign s_ready    = !valid_reg || byte_take;
    assign byte_valid = valid_reg;
    assign byte_data  = byte_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            byte_reg <= s_byte_in;
        end
    end

endmodule

// ----- hw/rtl/ltie_parser.sv -----
module ltie_parser
    import ltie_pkg::*;
#(
    parameter int LINE_LIMIT = LineLimitDefault
)
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       byte_valid,
    input  logic [7:0] byte_data,
    output logic       byte_take,
    input  logic       res_space,
    output result_t    res
);

    logic                inside_reg, inside_next;
    logic [7:0]          index_reg, index_next;
    logic [31:0]         acc_reg, acc_next;
    logic                neg_reg, neg_next;
    phase_t              phase_reg, phase_next;
    logic [31:0]         first_reg, first_next;
    logic [31:0]         second_reg, second_next;
    logic [LenWidth-1:0] len_reg, len_next;
    logic                stopped_reg, stopped_next;

    assign byte_take = byte_valid && (byte_data != CH_LF || res_space);

    always_comb begin
        logic [31:0] v;
        logic        fire;
        logic        do_close;
        v            = neg_reg ? (32'd0 - acc_reg) : acc_reg;
        fire         = byte_take;
        do_close     = 1'b0;
        inside_next  = inside_reg;
        index_next   = index_reg;
        acc_next     = acc_reg;
        neg_next     = neg_reg;
        phase_next   = phase_reg;
        first_next   = first_reg;
        second_next  = second_reg;
        len_next     = len_reg;
        stopped_next = stopped_reg;
        res.valid        = 1'b0;
        res.token_count  = index_reg;

        if (fire) begin
            if (byte_data == CH_LF) begin
                do_close  = 1'b1;
                res.valid = 1'b1;
            end else if (!stopped_reg && len_reg < LenWidth'(LINE_LIMIT)) begin
                len_next = len_reg + 1'b1;
                if (byte_data == CH_NUL) begin
                    do_close     = 1'b1;
                    stopped_next = 1'b1;
                end else if (byte_data == CH_SPACE || byte_data == CH_CR) begin
                    do_close = 1'b1;
                end else begin
                    if (!inside_reg) begin
                        inside_next = 1'b1;
                        if (index_reg != IDX_MAX) begin
                            index_next = index_reg + 1'b1;
                        end
                        acc_next   = 32'd0;
                        neg_next   = 1'b0;
                        phase_next = PH_AWAIT;
                    end
                    case (phase_next)
                        PH_AWAIT: begin
                            if (byte_data inside {CH_TAB, CH_VT, CH_FF}) begin
                                phase_next = PH_AWAIT;
                            end else if (byte_data == CH_PLUS || byte_data == CH_MINUS) begin
                                neg_next   = (byte_data == CH_MINUS);
                                phase_next = PH_DIGITS;
                            end else if (byte_data inside {[CH_ZERO:CH_NINE]}) begin
                                acc_next   = {24'd0, byte_data - CH_ZERO};
                                phase_next = PH_DIGITS;
                            end else begin
                                phase_next = PH_DONE;
                            end
                        end
                        PH_DIGITS: begin
                            if (byte_data inside {[CH_ZERO:CH_NINE]}) begin
                                acc_next = (acc_reg << 3) + (acc_reg << 1)
                                         + {24'd0, byte_data - CH_ZERO};
                            end else begin
                                phase_next = PH_DONE;
                            end
                        end
                        default: begin
                            phase_next = PH_DONE;
                        end
                    endcase
                end
            end
        end

        if (do_close && inside_reg) begin
            inside_next = 1'b0;
            if (index_reg == IDX_FIRST) begin
                first_next = v;
            end else if (index_reg == IDX_SECOND) begin
                second_next = v;
            end
        end

        res.first_value  = first_next;
        res.second_value = second_next;

        if (res.valid) begin
            inside_next  = 1'b0;
            index_next   = 8'd0;
            acc_next     = 32'd0;
            neg_next     = 1'b0;
            phase_next   = PH_AWAIT;
            len_next     = '0;
            stopped_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inside_reg  <= 1'b0;
            index_reg   <= 8'd0;
            acc_reg     <= 32'd0;
            neg_reg     <= 1'b0;
            phase_reg   <= PH_AWAIT;
            first_reg   <= 32'd0;
            second_reg  <= 32'd0;
            len_reg     <= '0;
            stopped_reg <= 1'b0;
        end else begin
            inside_reg  <= inside_next;
            index_reg   <= index_next;
            acc_reg     <= acc_next;
            neg_reg     <= neg_next;
            phase_reg   <= phase_next;
            first_reg   <= first_next;
            second_reg  <= second_next;
            len_reg     <= len_next;
            stopped_reg <= stopped_next;
        end
    end

endmodule

// ----- hw/rtl/ltie_out_reg.sv -----
module ltie_out_reg
    import ltie_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  result_t            res,
    output logic               res_space,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_first_value,
    output logic signed [31:0] m_second_value,
    output logic [7:0]         m_token_count
);

    logic        valid_reg;
    logic [31:0] first_reg;
    logic [31:0] second_reg;
    logic [7:0]  count_reg;

    assign res_space      = !valid_reg || m_ready;
    assign m_valid        = valid_reg;
    assign m_first_value  = signed'(first_reg);
    assign m_second_value = signed'(second_reg);
    assign m_token_count  = count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (res_space) begin
            valid_reg <= res.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res.valid) begin
            first_reg  <= res.first_value;
            second_reg <= res.second_value;
            count_reg  <= res.token_count;
        end
    end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import ltie_pkg::*;

    localparam int LineLimit = LineLimitDefault;

    typedef struct {
        logic signed [31:0] first_value;
        logic signed [31:0] second_value;
        logic [7:0]         token_count;
    } line_summary_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [7:0]         s_byte_in = 8'd0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [31:0] m_first_value;
    logic signed [31:0] m_second_value;
    logic [7:0]         m_token_count;

    line_summary_t pending_lines[$];
    int            mismatches = 0;
    int            sent_bytes = 0;
    bit            back_to_back = 1'b0;

    // Parser state mirrored from the block.
    logic        in_token = 1'b0;
    logic [7:0]  tokens_seen = 8'd0;
    logic [31:0] magnitude = 32'd0;
    logic        negative = 1'b0;
    phase_t      phase = PH_AWAIT;
    logic [31:0] value_a = 32'd0;
    logic [31:0] value_b = 32'd0;
    logic [7:0]  line_bytes = 8'd0;
    logic        line_dead = 1'b0;

    line_token_integer_extractor_unit #(
        .LINE_LIMIT(LineLimit)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_byte_in     (s_byte_in),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_first_value (m_first_value),
        .m_second_value(m_second_value),
        .m_token_count (m_token_count)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic void finish_token();
        logic [31:0] v;
        if (in_token) begin
            v = negative ? 32'd0 - magnitude : magnitude;
            if (tokens_seen == IDX_FIRST) begin
                value_a = v;
            end else if (tokens_seen == IDX_SECOND) begin
                value_b = v;
            end
            in_token = 1'b0;
        end
    endfunction

    function automatic void convert_char(input logic [7:0] c);
        logic is_digit;
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
        if (phase == PH_AWAIT) begin
            if (c != CH_TAB && c != CH_VT && c != CH_FF) begin
                if (c == CH_PLUS || c == CH_MINUS) begin
                    negative = (c == CH_MINUS);
                    phase = PH_DIGITS;
                end else if (is_digit) begin
                    magnitude = 32'(c) - 32'(CH_ZERO);
                    phase = PH_DIGITS;
                end else begin
                    phase = PH_DONE;
                end
            end
        end else if (phase == PH_DIGITS) begin
            if (is_digit) begin
                magnitude = magnitude * 32'd10 + (32'(c) - 32'(CH_ZERO));
            end else begin
                phase = PH_DONE;
            end
        end
    endfunction

    function automatic void parse_byte(input logic [7:0] c);
        line_summary_t s;
        if (c == CH_LF) begin
            finish_token();
            s.first_value = value_a;
            s.second_value = value_b;
            s.token_count = tokens_seen;
            pending_lines.push_back(s);
            in_token = 1'b0;
            tokens_seen = 8'd0;
            magnitude = 32'd0;
            negative = 1'b0;
            phase = PH_AWAIT;
            line_bytes = 8'd0;
            line_dead = 1'b0;
            return;
        end
        if (line_dead || line_bytes >= LineLimit) begin
            return;
        end
        line_bytes = line_bytes + 8'd1;
        if (c == CH_NUL) begin
            finish_token();
            line_dead = 1'b1;
        end else if (c == CH_SPACE || c == CH_CR) begin
            finish_token();
        end else begin
            if (!in_token) begin
                in_token = 1'b1;
                if (tokens_seen != IDX_MAX) begin
                    tokens_seen = tokens_seen + 8'd1;
                end
                magnitude = 32'd0;
                negative = 1'b0;
                phase = PH_AWAIT;
            end
            convert_char(c);
        end
    endfunction

    task automatic send_byte(input logic [7:0] c);
        while (!back_to_back && $urandom_range(0, 99) < 31) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        parse_byte(c);
        sent_bytes++;
        s_valid <= 1'b1;
        s_byte_in <= c;
        do begin
            @(posedge aclk);
        end while (!s_ready);
    endtask

    task automatic send_text(input string t);
        for (int i = 0; i < t.len(); i++) begin
            send_byte(8'(t[i]));
        end
    endtask

    task automatic send_line(input string t);
        send_text(t);
        send_byte(CH_LF);
    endtask

    function automatic logic [7:0] blank_char();
        case ($urandom_range(0, 2))
            0: return CH_TAB;
            1: return CH_VT;
            default: return CH_FF;
        endcase
    endfunction

    function automatic logic [7:0] noise_char();
        logic [7:0] c;
        c = 8'($urandom_range(1, 255));
        if (c == CH_LF || c == CH_CR || c == CH_SPACE) begin
            c = c + 8'd1;
        end
        return c;
    endfunction

    task automatic send_number();
        int n;
        if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 2)) send_byte(blank_char());
        end
        if ($urandom_range(0, 1) == 1) begin
            send_byte($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
        end
        n = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 14) : $urandom_range(1, 9);
        repeat (n) send_byte(8'(CH_ZERO + $urandom_range(0, 9)));
        if ($urandom_range(0, 7) == 0) begin
            send_byte(8'($urandom_range(33, 126)));
        end
    endtask

    task automatic send_gap();
        repeat ($urandom_range(1, 2)) send_byte($urandom_range(0, 3) == 0 ? CH_CR : CH_SPACE);
    endtask

    task automatic send_random_line();
        int kind;
        int n_tok;
        int pick;
        kind = $urandom_range(0, 99);
        if (kind < 8) begin
            repeat ($urandom_range(1, 20)) send_byte(8'($urandom));
        end else begin
            n_tok = (kind < 11) ? $urandom_range(25, 60) : $urandom_range(0, 7);
            if ($urandom_range(0, 3) == 0) begin
                send_gap();
            end
            for (int i = 0; i < n_tok; i++) begin
                if (i > 0) begin
                    send_gap();
                end
                pick = $urandom_range(0, 9);
                if (pick <= 5) begin
                    send_number();
                end else if (pick == 6) begin
                    repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(33, 126)));
                end else if (pick == 7) begin
                    send_byte($urandom_range(0, 1) ? CH_MINUS : blank_char());
                end else if (pick == 8) begin
                    repeat ($urandom_range(1, 3)) send_byte(noise_char());
                end else if ($urandom_range(0, 3) == 0) begin
                    send_byte(CH_NUL);
                end else begin
                    send_number();
                end
            end
            if ($urandom_range(0, 7) == 0) begin
                send_byte(CH_CR);
            end
        end
        send_byte(CH_LF);
    endtask

    task automatic test_number_forms();
        send_line("n m 0 -0");
        send_line("n m 2147483647 -2147483648");
        send_line("n m -2147483649 4294967295");
        send_line("n m 99999999999 +4294967296");
        send_text("n m ");
        send_byte(CH_TAB);
        send_byte(CH_VT);
        send_byte(CH_FF);
        send_line("-12ab +7x");
        send_line("n m + -");
        send_line("n m q5 5-");
        send_line("n m --3 +-4");
    endtask

    task automatic test_line_shapes();
        send_byte(CH_LF);
        send_line("a b 81 -92");
        send_line("a b");
        send_line("a b 63");
        send_text("a");
        send_byte(CH_CR);
        send_text("b");
        send_byte(CH_CR);
        send_text("31");
        send_byte(CH_CR);
        send_text("-41");
        send_byte(CH_CR);
        send_byte(CH_LF);
        send_text("a b 17");
        send_byte(CH_NUL);
        send_line(" 5 6");
        send_text("a b 11 22 ");
        repeat (70) send_text("z ");
        send_line("33 44");
        repeat (64) send_text("y ");
        send_line("5 6");
        send_line("1 2 3 4 5 6 7 8");
    endtask

    task automatic test_back_to_back();
        int start;
        start = sent_bytes;
        back_to_back = 1'b1;
        while (sent_bytes - start < 250) begin
            send_random_line();
        end
        back_to_back = 1'b0;
    endtask

    task automatic test_random_lines();
        while (sent_bytes < 1850) begin
            send_random_line();
        end
    endtask

    always @(posedge aclk) begin
        line_summary_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_lines.size() == 0) begin
                $error("result item with no line pending");
                mismatches++;
            end else begin
                want = pending_lines.pop_front();
                if (m_first_value !== want.first_value) begin
                    $error("first_value: expected %0d, got %0d",
                           want.first_value, m_first_value);
                    mismatches++;
                end
                if (m_second_value !== want.second_value) begin
                    $error("second_value: expected %0d, got %0d",
                           want.second_value, m_second_value);
                    mismatches++;
                end
                if (m_token_count !== want.token_count) begin
                    $error("token_count: expected %0d, got %0d",
                           want.token_count, m_token_count);
                    mismatches++;
                end
            end
        end
        m_ready <= back_to_back || ($urandom_range(0, 99) >= 31);
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        test_number_forms();
        test_line_shapes();
        test_back_to_back();
        test_random_lines();
        s_valid <= 1'b0;
        while (pending_lines.size() != 0) begin
            @(posedge aclk);
        end
        repeat (10) @(posedge aclk);
        if (mismatches == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("tb_top failed");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/ltie_pkg.sv
hw/rtl/ltie_in_reg.sv
hw/rtl/ltie_parser.sv
hw/rtl/ltie_out_reg.sv
hw/rtl/line_token_integer_extractor_unit.sv
tb/tb_top.sv
